[rtl/core/square_matrix_multiply_top_defines.svh]
// Assertion macros used by the square matrix multiplier checker
`ifndef SQUARE_MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define SQUARE_MATRIX_MULTIPLY_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define SMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset
`define SMM_ASSERT_RST(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/smm_pkg.sv]
// Shared types and constants of the square matrix multiplier
`default_nettype none

package smm_pkg;

  localparam int ELEM_BITS  = 16;
  localparam int PROD_W     = 2 * ELEM_BITS;
  localparam int IDX_W      = 3;
  localparam int SIDE_W     = IDX_W + 1;
  localparam int SIDE_LIMIT = 1 << IDX_W;
  localparam int CFG_W      = 2;

  typedef struct packed {
    logic signed [ELEM_BITS-1:0] a_elem;
    logic signed [ELEM_BITS-1:0] b_elem;
  } in_item_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] product;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic                     last;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/core/smm_ram.sv]
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic [AW-1:0]         raddr,
  output      logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/square_matrix_multiply_top.sv]
// Square matrix multiplier: loads A and B element pairs, then streams out C = A * B.
//
// Input channel (in_valid/in_ready/in_data): one transaction carries A[i] and B[i] at the
// same row-major position. in_ready is high only in the load phase, one transaction per
// cycle. The transaction that completes side*side elements starts the compute phase.
// Output channel (out_valid/out_ready/out_data): every element of C in row-major order,
// with row, column and a last flag on the final element. Sums wrap to 32 bits.
// Compute: one shared multiply-accumulate fed by two RAMs (A and B, one read each per
// cycle). For each element of C the sequencer issues side reads, then waits while the
// sum passes the RAM read, product, accumulator and output registers; the reads of the
// next element start only once the current sum is loaded into the output register.
// A stalled receiver holds the output register; the next element waits in the accumulator
// and compute pauses. The load phase of the next pair may start while the last result
// is still waiting to be taken.
// Configuration: cfg_we writes size_log2 (side = 2**size_log2, capped at MAX_SIDE) and
// discards a partial load. Reset (rst_n low, synchronous) sets size_log2 to 3, empties
// the load count and the output register; RAM contents are not cleared.
`default_nettype none

module square_matrix_multiply_top
  import smm_pkg::*;
#(
  parameter int MAX_SIDE = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire in_item_t         in_data,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      out_item_t        out_data,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int SIDE_CAP = (MAX_SIDE < SIDE_LIMIT) ? MAX_SIDE : SIDE_LIMIT;
  localparam int DEPTH    = SIDE_CAP * SIDE_CAP;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW       = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_CALC = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  size_log2_r, size_log2_nxt;
  logic [CW-1:0]     load_cnt_r, load_cnt_nxt;
  logic [IDX_W-1:0]  r_r, r_nxt, c_r, c_nxt, k_r, k_nxt;
  logic [AW-1:0]     a_ptr_r, a_ptr_nxt, b_ptr_r, b_ptr_nxt, row_base_r, row_base_nxt;

  logic                    t1_vld_r, t1_first_r, t1_last_r;
  logic                    t2_vld_r, t2_first_r, t2_last_r;
  logic signed [PROD_W-1:0] prod_r, acc_r;
  logic                    done_r;

  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic [SIDE_W-1:0]       side_pow, side, side_m1;
  logic [2*SIDE_W-1:0]     total_full;
  logic [CW-1:0]           total, load_cnt_inc;
  logic [AW-1:0]           side_aw;
  logic                    k_last, c_last, r_last;
  logic                    in_fire, out_load;
  logic signed [ELEM_BITS-1:0] a_rd, b_rd;

  // side length, element count and loop-end flags
  always_comb begin
    side_pow     = SIDE_W'(1) << size_log2_r;
    side         = (side_pow > SIDE_W'(SIDE_CAP)) ? SIDE_W'(SIDE_CAP) : side_pow;
    side_m1      = side - SIDE_W'(1);
    total_full   = side * side;
    total        = CW'(total_full);
    side_aw      = AW'(side);
    load_cnt_inc = load_cnt_r + CW'(1);
    k_last       = {1'b0, k_r} == side_m1;
    c_last       = {1'b0, c_r} == side_m1;
    r_last       = {1'b0, r_r} == side_m1;
  end

  assign in_ready = (state_r == ST_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == ST_WAIT) && done_r && (!out_valid_r || out_ready);

  // operand stores, written in row-major order during the load phase
  smm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (in_fire),
    .waddr (load_cnt_r[AW-1:0]),
    .wdata (in_data.a_elem),
    .raddr (a_ptr_r),
    .rdata (a_rd)
  );

  smm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (in_fire),
    .waddr (load_cnt_r[AW-1:0]),
    .wdata (in_data.b_elem),
    .raddr (b_ptr_r),
    .rdata (b_rd)
  );

  // sequencer: load, issue reads for one element, wait for its sum
  always_comb begin
    state_nxt     = state_r;
    size_log2_nxt = size_log2_r;
    load_cnt_nxt  = load_cnt_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    k_nxt         = k_r;
    a_ptr_nxt     = a_ptr_r;
    b_ptr_nxt     = b_ptr_r;
    row_base_nxt  = row_base_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (load_cnt_inc == total) begin
            state_nxt    = ST_CALC;
            load_cnt_nxt = '0;
            r_nxt        = '0;
            c_nxt        = '0;
            k_nxt        = '0;
            a_ptr_nxt    = '0;
            b_ptr_nxt    = '0;
            row_base_nxt = '0;
          end else begin
            load_cnt_nxt = load_cnt_inc;
          end
        end
      end
      ST_CALC: begin
        a_ptr_nxt = a_ptr_r + AW'(1);
        b_ptr_nxt = b_ptr_r + side_aw;
        k_nxt     = k_r + IDX_W'(1);
        if (k_last) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_load) begin
          k_nxt = '0;
          if (c_last) begin
            c_nxt        = '0;
            r_nxt        = r_r + IDX_W'(1);
            row_base_nxt = row_base_r + side_aw;
            a_ptr_nxt    = row_base_r + side_aw;
            b_ptr_nxt    = '0;
            state_nxt    = r_last ? ST_LOAD : ST_CALC;
          end else begin
            c_nxt     = c_r + IDX_W'(1);
            a_ptr_nxt = row_base_r;
            b_ptr_nxt = AW'(c_r + IDX_W'(1));
            state_nxt = ST_CALC;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
    // register write discards any partial load
    if (cfg_we) begin
      size_log2_nxt = cfg_wdata;
      load_cnt_nxt  = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      size_log2_r <= CFG_W'(3);
      load_cnt_r  <= '0;
      r_r         <= '0;
      c_r         <= '0;
      k_r         <= '0;
      a_ptr_r     <= '0;
      b_ptr_r     <= '0;
      row_base_r  <= '0;
      t1_vld_r    <= 1'b0;
      t2_vld_r    <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_log2_r <= size_log2_nxt;
      load_cnt_r  <= load_cnt_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
      k_r         <= k_nxt;
      a_ptr_r     <= a_ptr_nxt;
      b_ptr_r     <= b_ptr_nxt;
      row_base_r  <= row_base_nxt;
      t1_vld_r    <= (state_r == ST_CALC);
      t2_vld_r    <= t1_vld_r;
      if (t2_vld_r && t2_last_r) begin
        done_r <= 1'b1;
      end else if (out_load) begin
        done_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // MAC datapath: tags ride along with RAM data, product, then accumulate
  always_ff @(posedge clk) begin
    t1_first_r <= (k_r == '0);
    t1_last_r  <= k_last;
    t2_first_r <= t1_first_r;
    t2_last_r  <= t1_last_r;
    prod_r     <= PROD_W'(a_rd) * PROD_W'(b_rd);
    if (t2_vld_r) begin
      acc_r <= t2_first_r ? prod_r : acc_r + prod_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.product   <= acc_r;
      out_data_r.row_index <= r_r;
      out_data_r.col_index <= c_r;
      out_data_r.last      <= r_last && c_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/core/smm_chk.sv]
// Port-level checker for the square matrix multiplier, bound to the top level
`default_nettype none

`include "square_matrix_multiply_top_defines.svh"

module smm_chk
  import smm_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // a stalled result transaction holds its payload
  `SMM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // no loading while a product matrix is partly delivered
  `SMM_ASSERT_IMP(a_no_load_mid, clk, rst_n, out_valid && !out_data.last, !in_ready, "input accepted during compute")

  // the load phase ends only on an accepted transaction
  `SMM_ASSERT_NXT(a_ready_hold, clk, rst_n, in_ready && !in_valid, in_ready, "input ready dropped without a transaction")

  // reset empties the output register
  `SMM_ASSERT_RST(a_rst_empty, clk, !rst_n, !out_valid, "result valid after reset")

endmodule

bind square_matrix_multiply_top smm_chk u_smm_chk (.*);

`default_nettype wire
